FILE: design/assert_macros.svh
// Assertion macros shared by the section region translator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked assertion, switched off while reset is high.
`define SRT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked assertion that also holds during reset.
`define SRT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SRT_ASSERT(lbl, clk, rst, prop, msg)
`define SRT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: design/srt_pkg.sv
// Types and constants of the section region translator.
`timescale 1ns / 1ps
package srt_pkg;

  localparam int unsigned AW = 32;

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_INSERT = 3'd1,
    OP_MAP    = 3'd2,
    OP_VALID  = 3'd3,
    OP_SAME   = 3'd4
  } op_t;

  // Register byte addresses on the configuration port.
  localparam logic [2:0] REG_IMAGE_BASE = 3'd0;

  // One stored section.
  typedef struct packed {
    logic [AW-1:0] virt_start;
    logic [AW-1:0] file_offset;
    logic [AW-1:0] extent;
  } entry_t;

  // Command broadcast to every cell of the table.
  typedef struct packed {
    logic          ins;
    entry_t        new_ent;
    logic [AW-1:0] addr_a;
    logic [AW-1:0] rel_a;
    logic [AW-1:0] rel_b;
  } cmd_t;

  // Lookup results carried along the row of cells.
  typedef struct packed {
    logic          map_hit;
    logic [AW-1:0] map_addr;
    logic          valid_hit;
    logic          same_hit;
  } chain_t;

endpackage

FILE: design/section_region_translator.sv
// Top level of the section region translator: stream ports, register port and cell row.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// The block keeps up to MAX_SECTIONS sections sorted by file offset in a row of
// cells, one entry per cell, and takes one item per clock cycle: an insert moves
// the entries behind the insertion point one cell along in that same cycle, and
// map, valid and same-section lookups are answered by all cells at once with the
// result folded along the row. Every result lands in an output register in the
// cycle after its item; a new item is taken whenever that register is empty or
// being read in the same cycle. image_base may be changed only while idle.
module section_region_translator
  import srt_pkg::*;
#(
  parameter int unsigned MAX_SECTIONS = 16
) (
  input  logic         clk,
  input  logic         rst,
  // Input beats.
  input  logic         s_tvalid,
  output logic         s_tready,
  // [31:0] virt_start, [63:32] vsize, [95:64] file_offset,
  // [127:96] file_size, [159:128] addr_a, [191:160] addr_b
  input  logic [191:0] s_tdata,
  // [2:0] op
  input  logic [2:0]   s_tuser,
  // Result beats.
  output logic         m_tvalid,
  input  logic         m_tready,
  // [31:0] mapped_address
  output logic [31:0]  m_tdata,
  // [0] hit, [1] table_full
  output logic [1:0]   m_tuser,
  // Register port.
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int unsigned CNT_W = $clog2(MAX_SECTIONS + 1);

  logic [AW-1:0]    image_base;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             accept;
  logic             full;
  op_t              op;
  logic [AW-1:0]    vsize;
  logic [AW-1:0]    file_size;
  cmd_t             cmd;

  logic [MAX_SECTIONS-1:0] occ;
  logic [MAX_SECTIONS-1:0] gt;
  logic [MAX_SECTIONS-1:0] le;
  entry_t                  ent   [MAX_SECTIONS];
  chain_t                  chain [MAX_SECTIONS+1];

  logic          out_valid;
  logic          out_hit;
  logic          out_full;
  logic [AW-1:0] out_addr;
  logic          res_hit;
  logic          res_full;
  logic [AW-1:0] res_addr;

  // Register port: writes land on the access beat, reads return the register.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      image_base <= '0;
    end else if (psel && penable && pwrite && pready && paddr == REG_IMAGE_BASE) begin
      image_base <= pwdata;
    end
  end
  assign prdata = (paddr == REG_IMAGE_BASE) ? image_base : '0;

  // Input handshake and field unpacking.
  assign s_tready  = !out_valid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign op        = op_t'(s_tuser);
  assign vsize     = s_tdata[63:32];
  assign file_size = s_tdata[127:96];
  assign full      = (count == CNT_W'(MAX_SECTIONS));

  // Command broadcast to the cells.
  always_comb begin
    cmd.ins                 = accept && (op == OP_INSERT) && !full;
    cmd.new_ent.virt_start  = s_tdata[31:0];
    cmd.new_ent.file_offset = s_tdata[95:64];
    cmd.new_ent.extent      = (file_size > vsize) ? file_size : vsize;
    cmd.addr_a              = s_tdata[159:128];
    cmd.rel_a               = s_tdata[159:128] - image_base;
    cmd.rel_b               = s_tdata[191:160] - image_base;
  end

  // Section count.
  always_comb begin
    count_next = count;
    if (accept && op == OP_CLEAR) begin
      count_next = '0;
    end else if (cmd.ins) begin
      count_next = count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Row of cells; occupancy is the prefix below the count.
  assign chain[0] = '0;
  for (genvar i = 0; i < MAX_SECTIONS; i++) begin : g_cell
    assign occ[i] = CNT_W'(i) < count;
    srt_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .occ       (occ[i]),
      .prev_occ  ((i == 0) ? 1'b1 : occ[(i == 0) ? 0 : i-1]),
      .prev_gt   ((i == 0) ? 1'b0 : gt[(i == 0) ? 0 : i-1]),
      .prev_ent  (ent[(i == 0) ? 0 : i-1]),
      .next_le   ((i == MAX_SECTIONS-1) ? 1'b0 : le[(i == MAX_SECTIONS-1) ? i : i+1]),
      .chain_in  (chain[i]),
      .ent       (ent[i]),
      .gt        (gt[i]),
      .le        (le[i]),
      .chain_out (chain[i+1])
    );
  end

  // Result selection by operation.
  always_comb begin
    res_hit  = 1'b0;
    res_full = 1'b0;
    res_addr = '0;
    unique case (op)
      OP_CLEAR: begin
      end
      OP_INSERT: begin
        res_full = full;
      end
      OP_MAP: begin
        res_hit  = chain[MAX_SECTIONS].map_hit;
        res_addr = chain[MAX_SECTIONS].map_hit ?
                   chain[MAX_SECTIONS].map_addr + image_base : '0;
      end
      OP_VALID: begin
        res_hit = chain[MAX_SECTIONS].valid_hit;
      end
      OP_SAME: begin
        res_hit = chain[MAX_SECTIONS].same_hit;
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_hit  <= res_hit;
      out_full <= res_full;
      out_addr <= res_addr;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_addr;
  assign m_tuser  = {out_full, out_hit};

  `SRT_ASSERT(a_count_bound, clk, rst, count <= CNT_W'(MAX_SECTIONS), "section count above table depth")
  `SRT_ASSERT(a_clear_empties, clk, rst, accept && op == OP_CLEAR |=> count == '0, "clear left sections")
  `SRT_ASSERT(a_insert_counts, clk, rst, cmd.ins |=> count == $past(count) + 1'b1, "insert not counted")
  `SRT_ASSERT(a_full_only_insert, clk, rst, accept && op != OP_INSERT |=> !out_full, "full flag without insert")
  `SRT_ASSERT(a_hit_full_excl, clk, rst, out_valid |-> !(out_hit && out_full), "hit and full together")

endmodule

FILE: design/srt_cell.sv
// One table cell: holds a section entry and takes part in sorted insert and lookups.
`timescale 1ns / 1ps
module srt_cell
  import srt_pkg::*;
(
  input  logic   clk,
  input  cmd_t   cmd,
  input  logic   occ,
  input  logic   prev_occ,
  input  logic   prev_gt,
  input  entry_t prev_ent,
  input  logic   next_le,
  input  chain_t chain_in,
  output entry_t ent,
  output logic   gt,
  output logic   le,
  output chain_t chain_out
);

  logic          place;
  logic          sel;
  logic          in_a;
  logic          in_b;
  logic [AW:0]   range_end;
  logic [AW-1:0] map_val;

  // Ordering flags towards the neighbours.
  assign gt = occ && (ent.file_offset > cmd.new_ent.file_offset);
  assign le = occ && (cmd.addr_a >= ent.file_offset);

  // The new entry lands in the first cell that is free or holds a larger offset.
  assign place = cmd.ins && !prev_gt && (gt || !occ) && prev_occ;

  // Entry storage: shift right behind the insertion point, or take the new entry.
  always_ff @(posedge clk) begin
    if (cmd.ins && prev_gt) begin
      ent <= prev_ent;
    end else if (place) begin
      ent <= cmd.new_ent;
    end
  end

  // Range checks use a 33-bit end so a section reaching past 2^32 does not wrap.
  assign range_end = {1'b0, ent.virt_start} + {1'b0, ent.extent};
  assign in_a = ({1'b0, cmd.rel_a} >= {1'b0, ent.virt_start}) &&
                ({1'b0, cmd.rel_a} < range_end);
  assign in_b = ({1'b0, cmd.rel_b} >= {1'b0, ent.virt_start}) &&
                ({1'b0, cmd.rel_b} < range_end);

  // This cell maps the offset when it is the last one not above it.
  assign sel     = le && !next_le;
  assign map_val = cmd.addr_a - ent.file_offset + ent.virt_start;

  // Fold this cell's answers into the running results.
  always_comb begin
    chain_out.map_hit   = chain_in.map_hit | sel;
    chain_out.map_addr  = chain_in.map_addr | (sel ? map_val : '0);
    chain_out.valid_hit = chain_in.valid_hit | (occ && in_a);
    chain_out.same_hit  = chain_in.same_hit | (occ && in_a && in_b);
  end

endmodule

FILE: verif/tb_section_region_translator.sv
// Self-checking testbench for the section region translator: stream traffic, register writes.
`timescale 1ns / 1ps
module tb_section_region_translator;
  import srt_pkg::*;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned IDLE_LIMIT  = 4000;
  localparam int unsigned PHASE_ITEMS = 300;

  // One input beat as the generator sees it.
  typedef struct {
    logic [2:0]  op;
    logic [31:0] vs, vz, fo, fz, a, b;
  } req_t;

  // One expected result beat.
  typedef struct {
    logic        hit;
    logic [31:0] addr;
    logic        full;
  } res_t;

  logic         clk      = 1'b0;
  logic         rst      = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  // [31:0] virt_start, [63:32] vsize, [95:64] file_offset,
  // [127:96] file_size, [159:128] addr_a, [191:160] addr_b
  logic [191:0] s_tdata  = '0;
  // [2:0] op
  logic [2:0]   s_tuser  = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // [31:0] mapped_address
  logic [31:0]  m_tdata;
  // [0] hit, [1] table_full
  logic [1:0]   m_tuser;
  logic         psel     = 1'b0;
  logic         penable  = 1'b0;
  logic         pwrite   = 1'b0;
  logic [2:0]   paddr    = '0;
  logic [31:0]  pwdata   = '0;
  logic [31:0]  prdata;
  logic         pready;

  // Section table as the block should hold it.
  logic [31:0] tbl_vs [DEPTH];
  logic [31:0] tbl_fo [DEPTH];
  logic [31:0] tbl_ext[DEPTH];
  int          tbl_cnt   = 0;
  logic [31:0] base_model = '0;

  req_t req_q[$];
  res_t lookup_q[$];
  int   pending     = 0;
  int   errors      = 0;
  int   idle_cycles = 0;
  logic in_taken    = 1'b0;

  req_t cur;
  int   gap_left   = 0;
  int   burst_left = 1;
  int   rx_mode    = 0;
  int   rx_left    = 0;
  int   rx_cnt     = 0;

  section_region_translator #(.MAX_SECTIONS(DEPTH)) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // True when a relative address lies in stored section idx; the end is a 33-bit sum.
  function automatic logic in_sect(input int idx, input logic [31:0] rel);
    logic [32:0] lo;
    logic [32:0] hi;
    lo = {1'b0, tbl_vs[idx]};
    hi = lo + {1'b0, tbl_ext[idx]};
    return ({1'b0, rel} >= lo) && ({1'b0, rel} < hi);
  endfunction

  // Applies one accepted beat to the table and returns the result it should give.
  function automatic res_t translate_lookup(input logic [2:0] op, input logic [31:0] vs,
                                            input logic [31:0] vz, input logic [31:0] fo,
                                            input logic [31:0] fz, input logic [31:0] a,
                                            input logic [31:0] b);
    res_t        r;
    int          p;
    int          k;
    logic [31:0] ra;
    logic [31:0] rb;
    r  = '{hit: 1'b0, addr: '0, full: 1'b0};
    ra = a - base_model;
    rb = b - base_model;
    case (op)
      OP_CLEAR: tbl_cnt = 0;
      OP_INSERT: begin
        if (tbl_cnt >= DEPTH) begin
          r.full = 1'b1;
        end else begin
          // Entries with a larger offset move one place along.
          p = tbl_cnt;
          while (p > 0 && tbl_fo[p-1] > fo) begin
            tbl_vs[p]  = tbl_vs[p-1];
            tbl_fo[p]  = tbl_fo[p-1];
            tbl_ext[p] = tbl_ext[p-1];
            p--;
          end
          tbl_vs[p]  = vs;
          tbl_fo[p]  = fo;
          tbl_ext[p] = (fz > vz) ? fz : vz;
          tbl_cnt++;
        end
      end
      OP_MAP: begin
        k = 0;
        while (k < tbl_cnt && a >= tbl_fo[k]) k++;
        if (k > 0) begin
          r.hit  = 1'b1;
          r.addr = a - tbl_fo[k-1] + tbl_vs[k-1] + base_model;
        end
      end
      OP_VALID: begin
        for (k = 0; k < tbl_cnt; k++) if (in_sect(k, ra)) r.hit = 1'b1;
      end
      OP_SAME: begin
        for (k = 0; k < tbl_cnt; k++) if (in_sect(k, ra) && in_sect(k, rb)) r.hit = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Sender: bursts of random length with random gaps, changes on the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (gap_left > 0 || req_q.size() == 0) begin
        if (gap_left > 0) gap_left--;
        s_tvalid <= 1'b0;
      end else begin
        cur = req_q.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= cur.op;
        s_tdata  <= {cur.b, cur.a, cur.fz, cur.fo, cur.vz, cur.vs};
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // Receiver: stall pattern that switches mode every so often.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(20, 200);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        0:       m_tready <= 1'b1;
        1:       m_tready <= $urandom_range(0, 1);
        2:       m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= rx_cnt[2];
      endcase
      rx_cnt++;
    end
  end

  // Monitor: predicts on each input beat and checks each result beat.
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        lookup_q.push_back(translate_lookup(s_tuser, s_tdata[31:0], s_tdata[63:32],
                                            s_tdata[95:64], s_tdata[127:96],
                                            s_tdata[159:128], s_tdata[191:160]));
        pending--;
      end
      if (m_tvalid && m_tready) begin
        got = '{hit: m_tuser[0], addr: m_tdata, full: m_tuser[1]};
        if (lookup_q.size() == 0) begin
          $display("%0t: result beat with none expected, hit %0d addr %h full %0d",
                   $time, got.hit, got.addr, got.full);
          errors++;
        end else begin
          want = lookup_q.pop_front();
          if (got.hit !== want.hit) begin
            $display("%0t: hit mismatch, expected %0d, actual %0d", $time, want.hit, got.hit);
            errors++;
          end
          if (got.addr !== want.addr) begin
            $display("%0t: mapped_address mismatch, expected %h, actual %h",
                     $time, want.addr, got.addr);
            errors++;
          end
          if (got.full !== want.full) begin
            $display("%0t: table_full mismatch, expected %0d, actual %0d",
                     $time, want.full, got.full);
            errors++;
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
  end

  // Watchdog on cycles without any beat.
  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
    $display("tb: failure");
    $finish;
  end

  task automatic push_req(input logic [2:0] op, input logic [31:0] vs, input logic [31:0] vz,
                          input logic [31:0] fo, input logic [31:0] fz,
                          input logic [31:0] a, input logic [31:0] b);
    req_q.push_back('{op: op, vs: vs, vz: vz, fo: fo, fz: fz, a: a, b: b});
    pending++;
  endtask

  // Writes image_base over the register port and reads it back.
  task automatic write_base(input logic [31:0] value);
    logic [31:0] rd;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_IMAGE_BASE;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    base_model = value;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== value) begin
      $display("%0t: image_base read back mismatch, expected %h, actual %h", $time, value, rd);
      errors++;
    end
  endtask

  // Waits until every queued beat has gone in and every result has come out.
  task automatic wait_drained();
    do @(negedge clk); while (pending != 0 || lookup_q.size() != 0);
  endtask

  // Word biased towards the ends of the range.
  function automatic logic [31:0] any_word();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return $urandom_range(0, 255);
      3:       return 32'hFFFF_FFFF - $urandom_range(0, 255);
      default: return $urandom();
    endcase
  endfunction

  // Distance into a section of the given extent, mostly around its edges.
  function automatic logic [31:0] near_edge(input logic [31:0] ext);
    case ($urandom_range(0, 5))
      0:       return 32'hFFFF_FFFF;
      1:       return '0;
      2:       return ext - 32'd1;
      3:       return ext;
      4:       return $urandom();
      default: return $urandom_range(0, ext);
    endcase
  endfunction

  // Random traffic: mostly a clear, a run of inserts and lookups aimed at them, some noise.
  task automatic run_phase(input int n_items);
    int          made;
    int          n_ins;
    int          n_q;
    int          j;
    int          k;
    int          sel;
    logic [31:0] vs, vz, fo, fz, a, b;
    logic [31:0] s_vs[$];
    logic [31:0] s_fo[$];
    logic [31:0] s_ext[$];
    made = 0;
    while (made < n_items) begin
      if ($urandom_range(0, 4) == 0) begin
        push_req(3'($urandom_range(0, 7)), any_word(), any_word(), any_word(), any_word(),
                 any_word(), any_word());
        made++;
      end else begin
        push_req(OP_CLEAR, $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                 $urandom());
        made++;
        s_vs.delete();
        s_fo.delete();
        s_ext.delete();
        n_ins = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 8);
        for (k = 0; k < n_ins; k++) begin
          if (s_fo.size() > 0 && $urandom_range(0, 3) == 0)
            fo = s_fo[$urandom_range(0, s_fo.size() - 1)];
          else
            fo = $urandom_range(0, 1) ? 32'($urandom_range(0, 65535)) : any_word();
          vs = $urandom_range(0, 1) ? 32'($urandom_range(0, 1023) << 12) : any_word();
          vz = ($urandom_range(0, 3) == 0) ? any_word() : 32'($urandom_range(0, 8192));
          fz = ($urandom_range(0, 3) == 0) ? any_word() : 32'($urandom_range(0, 8192));
          push_req(OP_INSERT, vs, vz, fo, fz, $urandom(), $urandom());
          made++;
          if (s_vs.size() < DEPTH) begin
            s_vs.push_back(vs);
            s_fo.push_back(fo);
            s_ext.push_back((fz > vz) ? fz : vz);
          end
        end
        n_q = $urandom_range(4, 30);
        for (k = 0; k < n_q; k++) begin
          sel = $urandom_range(0, 2);
          if (s_vs.size() == 0) begin
            a = any_word();
            b = any_word();
          end else begin
            j = $urandom_range(0, s_vs.size() - 1);
            if (sel == 0) begin
              a = s_fo[j] + (($urandom_range(0, 1) == 0) ? near_edge(s_ext[j]) : $urandom());
              b = $urandom();
            end else begin
              a = s_vs[j] + near_edge(s_ext[j]) + base_model;
              if ($urandom_range(0, 2) == 0) j = $urandom_range(0, s_vs.size() - 1);
              b = s_vs[j] + near_edge(s_ext[j]) + base_model;
            end
          end
          case (sel)
            0:       push_req(OP_MAP, $urandom(), $urandom(), $urandom(), $urandom(), a, b);
            1:       push_req(OP_VALID, $urandom(), $urandom(), $urandom(), $urandom(), a, b);
            default: push_req(OP_SAME, $urandom(), $urandom(), $urandom(), $urandom(), a, b);
          endcase
          made++;
        end
      end
    end
  endtask

  // Reset, directed cases, then random phases under several load bases.
  initial begin
    logic [31:0] bases[6];
    logic [31:0] bd;
    int          k;
    bases = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom(), 32'h8000_0000, $urandom(),
              32'h0000_0001};
    bd    = 32'h0040_0000;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    write_base(bd);

    // Lookups on an empty table, and an unknown code.
    push_req(OP_MAP, 0, 0, 0, 0, 0, 0);
    push_req(OP_VALID, 0, 0, 0, 0, bd, 0);
    push_req(OP_SAME, 0, 0, 0, 0, bd, bd);
    push_req(3'd7, '1, '1, '1, '1, '1, '1);
    // Offset below every section, equal offsets, and a section reaching past 2^32.
    push_req(OP_INSERT, 32'h1000, 32'h200, 32'h400, 32'h300, 0, 0);
    push_req(OP_MAP, 0, 0, 0, 0, 32'h3FF, 0);
    push_req(OP_INSERT, 32'h2000, 32'h800, 32'h400, 32'h0, 0, 0);
    push_req(OP_INSERT, 32'hFFFF_FF00, 32'h1000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
    push_req(OP_MAP, 0, 0, 0, 0, 32'h400, 0);
    push_req(OP_MAP, 0, 0, 0, 0, 32'hFFFF_FFFF, 0);
    push_req(OP_VALID, 0, 0, 0, 0, bd + 32'h12FF, 0);
    push_req(OP_VALID, 0, 0, 0, 0, bd + 32'h1300, 0);
    push_req(OP_VALID, 0, 0, 0, 0, bd + 32'hFFFF_FFFF, 0);
    push_req(OP_SAME, 0, 0, 0, 0, bd + 32'h2000, bd + 32'h27FF);
    push_req(OP_SAME, 0, 0, 0, 0, bd + 32'h1000, bd + 32'h2000);
    // Fill the table in falling offset order, then one insert that is refused.
    for (k = 0; k < 14; k++)
      push_req(OP_INSERT, 32'(k << 16), 32'(k), 32'(32'h1000 * (14 - k)), 0, 0, 0);
    push_req(OP_CLEAR, 0, 0, 0, 0, 0, 0);
    push_req(OP_MAP, 0, 0, 0, 0, 32'hFFFF_FFFF, 0);
    wait_drained();

    for (k = 0; k < 6; k++) begin
      write_base(bases[k]);
      run_phase(PHASE_ITEMS);
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/srt_pkg.sv
design/srt_cell.sv
design/section_region_translator.sv
verif/tb_section_region_translator.sv
